>>> hdl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Phase codes, error codes, special byte values and the result group that
// travels from the decoder to the output serializer.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Decoder phase within a string body.
  typedef enum logic [2:0] {
    PH_NORMAL  = 3'd0,
    PH_ESC     = 3'd1,
    PH_HEX1    = 3'd2,
    PH_WANT_BS = 3'd3,
    PH_WANT_U  = 3'd4,
    PH_HEX2    = 3'd5
  } phase_t;

  // Error codes carried with a result.
  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_UNTERM  = 3'd1,
    ERR_ESCAPE  = 3'd2,
    ERR_UNICODE = 3'd3,
    ERR_CONTROL = 3'd4
  } err_t;

  // Special byte values.
  localparam logic [7:0] QUOTE_RESET  = 8'h22;
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_APOS      = 8'h27;
  localparam logic [7:0] CH_SLASH     = 8'h2f;
  localparam logic [7:0] CH_BSLASH    = 8'h5c;
  localparam logic [7:0] CH_DEL       = 8'h7f;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6e;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] BYTE_BS      = 8'h08;
  localparam logic [7:0] BYTE_FF      = 8'h0c;
  localparam logic [7:0] BYTE_LF      = 8'h0a;
  localparam logic [7:0] BYTE_CR      = 8'h0d;
  localparam logic [7:0] BYTE_TAB     = 8'h09;

  // Surrogate markers: top six bits of a high and a low surrogate.
  localparam logic [5:0] HI_SURR_TAG  = 6'b110110;
  localparam logic [5:0] LO_SURR_TAG  = 6'b110111;
  localparam logic [20:0] SUPP_BASE   = 21'h010000;

  // Largest number of bytes one input byte can produce.
  localparam int unsigned MAX_RES = 4;

  // Results caused by one input byte.
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [2:0]              count;
    logic                    string_end;
    err_t                    err;
  } res_group_t;

endpackage

>>> hdl/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode: escape and unicode decoder
// Holds the parse state and the quote register, and turns each accepted
// byte into a group of zero to four result bytes in the same cycle.
// ----------------------------------------------------------------------------
module jsu_decode
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       accept,
  input  logic [7:0] in_byte,
  output res_group_t res,
  output logic       res_valid
);

  phase_t      phase, phase_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [9:0]  hi_bits, hi_bits_next;
  logic [7:0]  quote_char;

  logic        hex_ok;
  logic [3:0]  hex_nib;
  logic [15:0] accum_shift;
  logic [20:0] supp_cp;

  // Encode a code point as UTF-8 bytes, first byte in lane 0.
  function automatic res_group_t utf8_encode(input logic [20:0] cp);
    res_group_t g;
    g = '0;
    g.err = ERR_NONE;
    if (cp <= 21'h00007f) begin
      g.bytes[0] = cp[7:0];
      g.count    = 3'd1;
    end else if (cp <= 21'h0007ff) begin
      g.bytes[0] = {3'b110, cp[10:6]};
      g.bytes[1] = {2'b10, cp[5:0]};
      g.count    = 3'd2;
    end else if (cp <= 21'h00ffff) begin
      g.bytes[0] = {4'b1110, cp[15:12]};
      g.bytes[1] = {2'b10, cp[11:6]};
      g.bytes[2] = {2'b10, cp[5:0]};
      g.count    = 3'd3;
    end else begin
      g.bytes[0] = {5'b11110, cp[20:18]};
      g.bytes[1] = {2'b10, cp[17:12]};
      g.bytes[2] = {2'b10, cp[11:6]};
      g.bytes[3] = {2'b10, cp[5:0]};
      g.count    = 3'd4;
    end
    return g;
  endfunction

  // Hex digit recognition.
  always_comb begin
    hex_ok  = 1'b1;
    hex_nib = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_nib = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hex_nib = in_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign accum_shift = {hex_accum[11:0], hex_nib};
  assign supp_cp     = {1'b0, hi_bits, accum_shift[9:0]} + SUPP_BASE;

  // Next state and result group for the byte at the input.
  always_comb begin
    phase_next     = phase;
    hex_count_next = hex_count;
    hex_accum_next = hex_accum;
    hi_bits_next   = hi_bits;
    res            = '0;
    res.err        = ERR_NONE;

    case (phase)
      PH_ESC: begin
        phase_next = PH_NORMAL;
        res.count  = 3'd1;
        case (in_byte)
          CH_NUL:    res.err = ERR_UNTERM;
          CH_DQUOTE,
          CH_APOS,
          CH_BSLASH,
          CH_SLASH:  res.bytes[0] = in_byte;
          CH_B:      res.bytes[0] = BYTE_BS;
          CH_F:      res.bytes[0] = BYTE_FF;
          CH_N:      res.bytes[0] = BYTE_LF;
          CH_R:      res.bytes[0] = BYTE_CR;
          CH_T:      res.bytes[0] = BYTE_TAB;
          CH_U: begin
            res.count      = 3'd0;
            phase_next     = PH_HEX1;
            hex_count_next = 2'd0;
            hex_accum_next = 16'd0;
          end
          default:   res.err = ERR_ESCAPE;
        endcase
      end

      PH_HEX1, PH_HEX2: begin
        if (!hex_ok) begin
          res.count = 3'd1;
          res.err   = ERR_UNICODE;
        end else if (hex_count != 2'd3) begin
          hex_accum_next = accum_shift;
          hex_count_next = hex_count + 2'd1;
        end else if (phase == PH_HEX1) begin
          if (accum_shift[15:10] == HI_SURR_TAG) begin
            hi_bits_next   = accum_shift[9:0];
            hex_accum_next = 16'd0;
            hex_count_next = 2'd0;
            phase_next     = PH_WANT_BS;
          end else begin
            res = utf8_encode({5'd0, accum_shift});
          end
        end else if (accum_shift[15:10] == LO_SURR_TAG) begin
          res = utf8_encode(supp_cp);
        end else begin
          res.count = 3'd1;
          res.err   = ERR_UNICODE;
        end
      end

      PH_WANT_BS: begin
        if (in_byte == CH_BSLASH) begin
          phase_next = PH_WANT_U;
        end else begin
          res.count = 3'd1;
          res.err   = ERR_UNICODE;
        end
      end

      PH_WANT_U: begin
        if (in_byte == CH_U) begin
          phase_next     = PH_HEX2;
          hex_count_next = 2'd0;
          hex_accum_next = 16'd0;
        end else begin
          res.count = 3'd1;
          res.err   = ERR_UNICODE;
        end
      end

      default: begin
        // Normal text, also for unused phase codes.
        phase_next = PH_NORMAL;
        res.count  = 3'd1;
        if (in_byte == quote_char) begin
          res.string_end = 1'b1;
        end else if (in_byte == CH_BSLASH) begin
          res.count  = 3'd0;
          phase_next = PH_ESC;
        end else if (in_byte == CH_NUL) begin
          res.err = ERR_UNTERM;
        end else if (in_byte < CH_SPACE || in_byte == CH_DEL) begin
          res.err = ERR_CONTROL;
        end else begin
          res.bytes[0] = in_byte;
        end
      end
    endcase

    // A string end, an error or an emitted code point returns to normal text.
    if (res.count != 3'd0 && phase != PH_ESC && !(phase == PH_NORMAL && !res.string_end &&
        res.err == ERR_NONE)) begin
      phase_next     = PH_NORMAL;
      hex_count_next = 2'd0;
      hex_accum_next = 16'd0;
      hi_bits_next   = 10'd0;
    end
    if (phase == PH_ESC && res.err != ERR_NONE) begin
      hex_count_next = 2'd0;
      hex_accum_next = 16'd0;
      hi_bits_next   = 10'd0;
    end
  end

  assign res_valid = accept && (res.count != 3'd0);

  // State register, advanced on each input transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_NORMAL;
      hex_count <= 2'd0;
      hex_accum <= 16'd0;
      hi_bits   <= 10'd0;
    end else if (accept) begin
      phase     <= phase_next;
      hex_count <= hex_count_next;
      hex_accum <= hex_accum_next;
      hi_bits   <= hi_bits_next;
    end
  end

  // Quote register.
  always_ff @(posedge clk) begin
    if (rst) begin
      quote_char <= QUOTE_RESET;
    end else if (cfg_wr_en) begin
      quote_char <= cfg_wr_data;
    end
  end

endmodule

>>> hdl/jsu_serialize.sv
// ----------------------------------------------------------------------------
// jsu_serialize: result group register and output serializer
// Holds one group of up to four result bytes and hands them out one per
// output transaction, marking the final byte of the group.
// ----------------------------------------------------------------------------
module jsu_serialize
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  res_group_t load_group,
  output logic       can_load,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic [3:0] m_tuser,
  output logic       m_tlast
);

  res_group_t grp;
  logic       grp_valid;
  logic [1:0] idx;
  logic       at_last;
  logic       take;

  assign at_last  = ({1'b0, idx} == (grp.count - 3'd1));
  assign take     = grp_valid && m_tready;
  assign can_load = !grp_valid || (take && at_last);

  assign m_tvalid = grp_valid;
  assign m_tdata  = grp.bytes[idx];
  assign m_tuser  = {grp.err, grp.string_end};
  assign m_tlast  = at_last;

  // Control: group valid flag and byte index.
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      grp_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (take) begin
      if (at_last) begin
        grp_valid <= 1'b0;
        idx       <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      grp <= load_group;
    end
  end

endmodule

>>> hdl/json_string_unescape_utf8_unit.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit: JSON string body unescaper with UTF-8 output
// Feed the bytes after a string's opening quote; decoded bytes come out.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one raw body byte per transaction. The master
//   stream returns one result byte per transaction: tdata is the decoded
//   byte, tuser flags a string end or an error, and tlast marks the final
//   result caused by one input byte. Backslashes, hex digits and surrogate
//   glue cause no result; a \u escape causes one to four UTF-8 bytes.
//   An input transaction's first result appears in the cycle after it.
//   Throughput is one input byte per cycle while each byte causes at most
//   one result and the receiver is ready; the single output register sends
//   one byte per cycle while the receiver is ready. The input is accepted
//   while the output register is empty or sends its final byte, so a
//   stalled receiver stalls the input after one group.
//   Reset empties the output, returns the parser to normal text and sets
//   the quote byte to a double quote. The user writes the quote byte through
//   cfg_wr_en and cfg_wr_data while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,   // quote_char
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,       // [7:0] in_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,       // [7:0] out_byte
  output logic [3:0] m_tuser,       // [0] string_end, [3:1] error_code
  output logic       m_tlast        // last
);

  logic       accept;
  logic       can_load;
  logic       res_valid;
  res_group_t res;

  assign s_tready = can_load;
  assign accept   = s_tvalid && can_load;

  // Parser and quote register.
  jsu_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .in_byte     (s_tdata),
    .res         (res),
    .res_valid   (res_valid)
  );

  // Output register and byte serializer.
  jsu_serialize u_serialize (
    .clk        (clk),
    .rst        (rst),
    .load       (res_valid),
    .load_group (res),
    .can_load   (can_load),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the JSON string unescaper
// Streams raw string-body bytes into the unit under several quote bytes and
// compares every output transaction with a cycle-free predictor of the
// decoder. A short directed run covers byte extremes, errors and a maximum
// surrogate pair. A longer random run follows, built mostly from well-formed
// pieces with random content plus broken sequences and noise. Both stream
// sides idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import jsu_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PRESSURE_CYCLES = 80;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 10;

  localparam logic [15:0] HI_SURR_FIRST = 16'hd800;
  localparam logic [15:0] HI_SURR_LAST  = 16'hdbff;
  localparam logic [15:0] LO_SURR_FIRST = 16'hdc00;
  localparam logic [15:0] LO_SURR_LAST  = 16'hdfff;

  // One decoded output transaction.
  typedef struct {
    logic [7:0] data;
    logic       string_end;
    err_t       err;
    logic       is_last;
  } decoded_t;

  // Predicts decoded bytes from accepted raw bytes and checks the output.
  class unescape_scoreboard;
    decoded_t   expected_q[$];
    logic [7:0] quote;
    phase_t     phase;
    logic [1:0] digit_count;
    logic [15:0] hex_acc;
    logic [9:0] high_bits;
    int         bytes_in;
    int         results_ok;
    int         ends_seen;
    int         errors_seen;
    int         mismatches;

    function new();
      quote = QUOTE_RESET;
      clear_parse();
    endfunction

    function void clear_parse();
      phase       = PH_NORMAL;
      digit_count = 2'd0;
      hex_acc     = 16'd0;
      high_bits   = 10'd0;
    endfunction

    function void push_result(logic [7:0] data, logic str_end, err_t err, logic is_last);
      decoded_t r;
      r.data       = data;
      r.string_end = str_end;
      r.err        = err;
      r.is_last    = is_last;
      expected_q   = {expected_q, r};
    endfunction

    // An error drops the string and resets the parser.
    function void push_error(err_t err);
      clear_parse();
      push_result(8'h00, 1'b0, err, 1'b1);
    endfunction

    function int hex_value(logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
      if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
      if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
      return -1;
    endfunction

    // Code point to one through four UTF-8 bytes.
    function void push_utf8(logic [20:0] cp);
      if (cp <= 21'h7f) begin
        push_result(cp[7:0], 1'b0, ERR_NONE, 1'b1);
      end else if (cp <= 21'h7ff) begin
        push_result({3'b110, cp[10:6]}, 1'b0, ERR_NONE, 1'b0);
        push_result({2'b10, cp[5:0]}, 1'b0, ERR_NONE, 1'b1);
      end else if (cp <= 21'hffff) begin
        push_result({4'b1110, cp[15:12]}, 1'b0, ERR_NONE, 1'b0);
        push_result({2'b10, cp[11:6]}, 1'b0, ERR_NONE, 1'b0);
        push_result({2'b10, cp[5:0]}, 1'b0, ERR_NONE, 1'b1);
      end else begin
        push_result({5'b11110, cp[20:18]}, 1'b0, ERR_NONE, 1'b0);
        push_result({2'b10, cp[17:12]}, 1'b0, ERR_NONE, 1'b0);
        push_result({2'b10, cp[11:6]}, 1'b0, ERR_NONE, 1'b0);
        push_result({2'b10, cp[5:0]}, 1'b0, ERR_NONE, 1'b1);
      end
    endfunction

    // Advances the parser by one accepted raw byte.
    function void decode_byte(logic [7:0] b);
      int v;
      v = hex_value(b);
      bytes_in++;
      case (phase)
        PH_ESC: begin
          phase = PH_NORMAL;
          case (b)
            CH_NUL: push_error(ERR_UNTERM);
            CH_APOS, CH_DQUOTE, CH_BSLASH, CH_SLASH: push_result(b, 1'b0, ERR_NONE, 1'b1);
            CH_B: push_result(BYTE_BS, 1'b0, ERR_NONE, 1'b1);
            CH_F: push_result(BYTE_FF, 1'b0, ERR_NONE, 1'b1);
            CH_N: push_result(BYTE_LF, 1'b0, ERR_NONE, 1'b1);
            CH_R: push_result(BYTE_CR, 1'b0, ERR_NONE, 1'b1);
            CH_T: push_result(BYTE_TAB, 1'b0, ERR_NONE, 1'b1);
            CH_U: begin
              phase       = PH_HEX1;
              digit_count = 2'd0;
              hex_acc     = 16'd0;
            end
            default: push_error(ERR_ESCAPE);
          endcase
        end
        PH_HEX1, PH_HEX2: begin
          if (v < 0) begin
            push_error(ERR_UNICODE);
          end else begin
            hex_acc = {hex_acc[11:0], v[3:0]};
            if (digit_count < 2'd3) begin
              digit_count++;
            end else if (phase == PH_HEX1) begin
              digit_count = 2'd0;
              // A high surrogate waits for its low half.
              if (hex_acc >= HI_SURR_FIRST && hex_acc <= HI_SURR_LAST) begin
                high_bits = hex_acc[9:0];
                hex_acc   = 16'd0;
                phase     = PH_WANT_BS;
              end else begin
                push_utf8({5'd0, hex_acc});
                clear_parse();
              end
            end else if (hex_acc >= LO_SURR_FIRST && hex_acc <= LO_SURR_LAST) begin
              push_utf8({1'b0, high_bits, hex_acc[9:0]} + 21'h010000);
              clear_parse();
            end else begin
              push_error(ERR_UNICODE);
            end
          end
        end
        PH_WANT_BS: begin
          if (b != CH_BSLASH) push_error(ERR_UNICODE);
          else phase = PH_WANT_U;
        end
        PH_WANT_U: begin
          if (b != CH_U) begin
            push_error(ERR_UNICODE);
          end else begin
            phase       = PH_HEX2;
            digit_count = 2'd0;
            hex_acc     = 16'd0;
          end
        end
        default: begin
          // Normal text: quote first, then backslash, zero and control bytes.
          phase = PH_NORMAL;
          if (b == quote) begin
            clear_parse();
            push_result(8'h00, 1'b1, ERR_NONE, 1'b1);
          end else if (b == CH_BSLASH) begin
            phase = PH_ESC;
          end else if (b == CH_NUL) begin
            push_error(ERR_UNTERM);
          end else if (b < CH_SPACE || b == CH_DEL) begin
            push_error(ERR_CONTROL);
          end else begin
            push_result(b, 1'b0, ERR_NONE, 1'b1);
          end
        end
      endcase
    endfunction

    task report(string msg);
      if (mismatches < 20) $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_result(logic [7:0] data, logic [3:0] user, logic is_last);
      decoded_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected transaction data=%02h user=%h last=%b",
                         data, user, is_last));
        return;
      end
      want = expected_q.pop_front();
      if (data !== want.data)
        report($sformatf("data %02h, expected %02h", data, want.data));
      if (user[0] !== want.string_end)
        report($sformatf("string_end %b, expected %b", user[0], want.string_end));
      if (user[3:1] !== want.err)
        report($sformatf("error_code %0d, expected %0d", user[3:1], want.err));
      if (is_last !== want.is_last)
        report($sformatf("last %b, expected %b", is_last, want.is_last));
      results_ok++;
      if (want.string_end) ends_seen++;
      if (want.err != ERR_NONE) errors_seen++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic [3:0] m_tuser;
  logic       m_tlast;

  unescape_scoreboard sb;
  logic [7:0] raw_q[$];
  bit  tx_gaps;
  bit  rx_stalls;
  bit  pressure_req;
  int  quote_writes;
  int  idle_cycles;

  json_string_unescape_utf8_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  always #5 clk = ~clk;

  // Mostly no gap, often a short one, now and then a long one.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Monitors: record input transactions and check output transactions.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.decode_byte(s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, or one long hold-off when requested.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_req) begin
        m_tready <= 1'b0;
        repeat (PRESSURE_CYCLES - 1) @(posedge clk);
        pressure_req = 1'b0;
      end else if (!rst && rx_stalls && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        m_tready <= !rst;
      end
    end
  end

  task send_byte(logic [7:0] b);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
  endtask

  task send_raw();
    while (raw_q.size() > 0) send_byte(raw_q.pop_front());
  endtask

  // Stop offering, wait for every expected result, then let the block settle.
  // The first edge lets the monitor record the final input transaction.
  task wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_quote(logic [7:0] q);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= q;
    @(posedge clk);
    sb.quote = q;
    quote_writes++;
    cfg_wr_en <= 1'b0;
  endtask

  // Appends one raw byte to the stimulus queue.
  function void queue_raw(logic [7:0] b);
    raw_q = {raw_q, b};
  endfunction

  // Four hex digits, letters in random case.
  task push_hex(logic [15:0] v);
    logic [3:0] nib;
    for (int i = 3; i >= 0; i--) begin
      nib = v[i*4 +: 4];
      if (nib < 4'd10) queue_raw(8'h30 + nib);
      else queue_raw(($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 8'd10);
    end
  endtask

  task push_uescape(logic [15:0] v);
    queue_raw(CH_BSLASH);
    queue_raw(CH_U);
    push_hex(v);
  endtask

  function logic [7:0] pick_escape();
    case ($urandom_range(0, 8))
      0: return CH_DQUOTE;
      1: return CH_APOS;
      2: return CH_BSLASH;
      3: return CH_SLASH;
      4: return CH_B;
      5: return CH_F;
      6: return CH_N;
      7: return CH_R;
      default: return CH_T;
    endcase
  endfunction

  // Appends one piece of string body: mostly well formed, some broken.
  task add_piece();
    int r;
    logic [15:0] v;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      c = 8'($urandom_range(8'h20, 8'hff));
      if (c == sb.quote || c == CH_BSLASH || c == CH_DEL) c = 8'h61;
      queue_raw(c);
    end else if (r < 45) begin
      queue_raw(CH_BSLASH);
      queue_raw(pick_escape());
    end else if (r < 60) begin
      case ($urandom_range(0, 3))
        0: v = 16'($urandom_range(16'h0000, 16'h007f));
        1: v = 16'($urandom_range(16'h0080, 16'h07ff));
        2: v = 16'($urandom_range(16'h0800, 16'hd7ff));
        default: v = 16'($urandom_range(16'he000, 16'hffff));
      endcase
      push_uescape(v);
    end else if (r < 70) begin
      push_uescape(HI_SURR_FIRST + 16'($urandom_range(0, 1023)));
      push_uescape(LO_SURR_FIRST + 16'($urandom_range(0, 1023)));
    end else if (r < 74) begin
      push_uescape(LO_SURR_FIRST + 16'($urandom_range(0, 1023)));
    end else if (r < 80) begin
      queue_raw(sb.quote);
    end else begin
      case ($urandom_range(0, 6))
        0: queue_raw(8'($urandom_range(0, 255)));
        1: begin
          queue_raw(CH_BSLASH);
          queue_raw(8'($urandom_range(0, 255)));
        end
        2: queue_raw($urandom_range(0, 3) == 0 ? CH_DEL : 8'($urandom_range(0, 31)));
        3: begin
          // Truncated hex digits followed by a non-hex byte.
          queue_raw(CH_BSLASH);
          queue_raw(CH_U);
          v = 16'($urandom_range(0, 16'hffff));
          for (int i = $urandom_range(0, 3); i > 0; i--) queue_raw(8'h30 + v[i]);
          queue_raw($urandom_range(0, 1) ? 8'($urandom_range(8'h67, 8'h7a))
                                         : 8'($urandom_range(8'h00, 8'h2f)));
        end
        4: begin
          push_uescape(HI_SURR_FIRST + 16'($urandom_range(0, 1023)));
          queue_raw(8'($urandom_range(0, 255)));
        end
        5: begin
          push_uescape(HI_SURR_FIRST + 16'($urandom_range(0, 1023)));
          queue_raw(CH_BSLASH);
          queue_raw(8'($urandom_range(0, 255)));
        end
        default: begin
          push_uescape(HI_SURR_FIRST + 16'($urandom_range(0, 1023)));
          push_uescape(16'($urandom_range(0, 16'hffff)));
        end
      endcase
    end
  endtask

  task run_random(int n_bytes);
    while (raw_q.size() < n_bytes) add_piece();
    send_raw();
  endtask

  initial begin
    sb = new();
    rst          <= 1'b1;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= 8'h00;
    s_tvalid     <= 1'b0;
    s_tdata      <= 8'h00;
    tx_gaps      = 1'b1;
    rx_stalls    = 1'b1;
    pressure_req = 1'b0;
    quote_writes = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: plain extremes, control and zero bytes, escape errors,
    // quote inside an escape, a lone low surrogate and the top surrogate pair.
    raw_q = '{8'h41, CH_SPACE, 8'h7e, 8'h80, 8'hff, CH_DEL, 8'h01, 8'h1f, CH_NUL,
              CH_BSLASH, CH_N, CH_BSLASH, CH_NUL, CH_BSLASH, 8'h78,
              CH_BSLASH, CH_DQUOTE};
    push_uescape(LO_SURR_FIRST);
    push_uescape(HI_SURR_LAST);
    push_uescape(LO_SURR_LAST);
    queue_raw(CH_DQUOTE);
    send_raw();

    run_random(100);

    // Apostrophe as quote, no idling on either side.
    write_quote(CH_APOS);
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    run_random(80);

    // Highest quote byte; the receiver holds off while input keeps coming.
    write_quote(8'hff);
    pressure_req = 1'b1;
    run_random(40);
    tx_gaps = 1'b1;
    run_random(30);

    // Lowest quote byte: a zero byte now ends the string.
    write_quote(8'h00);
    tx_gaps   = 1'b0;
    rx_stalls = 1'b1;
    run_random(50);

    // Backslash and a control byte as quote take precedence in normal text.
    write_quote(CH_BSLASH);
    tx_gaps = 1'b1;
    run_random(30);
    write_quote(BYTE_LF);
    run_random(30);

    write_quote(CH_DQUOTE);
    run_random(50);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("Run covered %0d raw bytes and %0d decoded transactions over %0d quote writes.",
             sb.bytes_in, sb.results_ok, quote_writes);
    $display("String ends seen: %0d, error results seen: %0d, mismatches: %0d.",
             sb.ends_seen, sb.errors_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
